@@ sv/filled_circle_span_generator_unit_macros.svh @@
// Assertion macros shared by the filled circle span generator RTL.
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_UNIT_MACROS_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCSG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/fcsg_pkg.sv @@
// Package with the types and constants of the filled circle span generator.
`timescale 1ns / 1ps

package fcsg_pkg;

   localparam int RADIUS_BITS_DEFAULT = 10;
   localparam int QUEUE_DEPTH         = 4;
   localparam int COORD_BITS          = 13;
   localparam int SPAN_SLOTS          = 6;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      SLOT_UP_INNER = 3'd0,
      SLOT_DN_INNER = 3'd1,
      SLOT_UP_OUTER = 3'd2,
      SLOT_DN_OUTER = 3'd3,
      SLOT_UP_TAIL  = 3'd4,
      SLOT_DN_TAIL  = 3'd5
   } span_slot_type;

   typedef struct packed {
      logic main;
      logic nonzero;
      logic outer_rows;
      logic tail;
      logic finish;
   } span_flags_type;

   localparam int FLAG_BITS = $bits(span_flags_type);

endpackage

@@ sv/filled_circle_span_generator_unit.sv @@
// Top level of the filled circle span generator: front end, descriptor queue and back end.
//
//   Channel | Direction | Data fields (lowest bit first)                | Sideband
//   req     | in        | center_x, center_y, radius, fill_color        | tuser opcode
//   rsp     | out       | row, x_left, x_right, span_color, pad bit     | tlast, tuser
//
// A start beat yields no span, as does a step taken while idle. A step beat taken while
// a circle is in progress yields one to six spans, which the back end sends at one span
// per cycle while the result channel is not stalled. Reset is synchronous and clears the
// control state; no clearing pass follows it. The front end keeps taking beats while the
// descriptor queue has room, even when the result channel is stalled; a full queue holds
// req_tready low.
`timescale 1ns / 1ps

`include "filled_circle_span_generator_unit_macros.svh"

module filled_circle_span_generator_unit import fcsg_pkg::*; #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // center_x, center_y, radius, fill_color
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // row, x_left, x_right, span_color, zero pad
   output logic        rsp_tlast,   // last_of_step
   output logic        rsp_tuser    // circle_done
);

   localparam int QueueWidth = FLAG_BITS + 46 + 3 * RADIUS_BITS;

   logic                   q_push, q_pop, q_empty, q_full;
   logic [QueueWidth-1:0]  q_wdata, q_rdata;
   logic                   busy;
   logic                   start_beat;

   span_flags_type         f_flags, b_flags;
   logic [10:0]            f_col, f_row, b_col, b_row;
   logic [23:0]            f_color, b_color;
   logic [RADIUS_BITS-1:0] f_inner, f_outer, f_end;
   logic [RADIUS_BITS-1:0] b_inner, b_outer, b_end;

   fcsg_front #(
      .RADIUS_BITS(RADIUS_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_full    (q_full),
      .q_push    (q_push),
      .d_flags   (f_flags),
      .d_col     (f_col),
      .d_row     (f_row),
      .d_color   (f_color),
      .d_inner   (f_inner),
      .d_outer   (f_outer),
      .d_end     (f_end),
      .busy      (busy)
   );

   assign q_wdata = {f_flags, f_col, f_row, f_color, f_inner, f_outer, f_end};

   fcsg_queue #(
      .DATA_WIDTH(QueueWidth),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_data(q_wdata),
      .pop    (q_pop),
      .rd_data(q_rdata),
      .empty  (q_empty),
      .full   (q_full)
   );

   assign {b_flags, b_col, b_row, b_color, b_inner, b_outer, b_end} = q_rdata;

   fcsg_back #(
      .RADIUS_BITS(RADIUS_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .d_flags   (b_flags),
      .d_col     (b_col),
      .d_row     (b_row),
      .d_color   (b_color),
      .d_inner   (b_inner),
      .d_outer   (b_outer),
      .d_end     (b_end),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   assign start_beat = req_tvalid && req_tready && (req_tuser == OP_START);

   `FCSG_ASSERT_NOW(a_push_has_room, clock, reset, q_push, !q_full, "Push into a full queue")
   `FCSG_ASSERT_NOW(a_pop_has_data, clock, reset, q_pop, !q_empty, "Pop from an empty queue")
   `FCSG_ASSERT_NOW(a_done_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "Done off last")
   `FCSG_ASSERT_NEXT(a_start_sets_busy, clock, reset, start_beat, busy, "Start left it idle")

endmodule

@@ sv/fcsg_queue.sv @@
// Short first-in first-out queue of step descriptors between front and back.
`timescale 1ns / 1ps

module fcsg_queue import fcsg_pkg::*; #(
   parameter int DATA_WIDTH = 64,
   parameter int DEPTH      = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] rd_data,
   output logic                  empty,
   output logic                  full
);

   localparam int AddrBits  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountBits = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [AddrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AddrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]  count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CountBits'(DEPTH));
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AddrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + AddrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + AddrBits'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ sv/fcsg_front.sv @@
// Front end: accepts beats, keeps the circle state and issues step descriptors.
`timescale 1ns / 1ps

module fcsg_front import fcsg_pkg::*; #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [55:0]            req_tdata,
   input  logic                   req_tuser,
   input  logic                   q_full,
   output logic                   q_push,
   output span_flags_type         d_flags,
   output logic [10:0]            d_col,
   output logic [10:0]            d_row,
   output logic [23:0]            d_color,
   output logic [RADIUS_BITS-1:0] d_inner,
   output logic [RADIUS_BITS-1:0] d_outer,
   output logic [RADIUS_BITS-1:0] d_end,
   output logic                   busy
);

   localparam int ErrBits = RADIUS_BITS + 5;

   logic [10:0]            centre_col_ff, centre_col_in;
   logic [10:0]            centre_row_ff, centre_row_in;
   logic [23:0]            color_ff, color_in;
   logic [RADIUS_BITS-1:0] inner_ff, inner_in;
   logic [RADIUS_BITS-1:0] outer_ff, outer_in;
   logic [ErrBits-1:0]     err_ff, err_in;
   logic                   busy_ff, busy_in;

   logic                   accept;
   op_type                 opcode;
   logic [RADIUS_BITS-1:0] radius_r;
   logic                   main;
   logic                   err_neg;
   logic [ErrBits-1:0]     inner_ext, outer_ext, inc_small, inc_big;
   logic [RADIUS_BITS-1:0] step_inner, step_outer;
   logic [ErrBits-1:0]     step_err;
   logic                   finish;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign opcode     = op_type'(req_tuser);
   assign radius_r   = RADIUS_BITS'(req_tdata[31:22]);

   always_comb begin
      main       = (inner_ff < outer_ff);
      err_neg    = err_ff[ErrBits-1];
      inner_ext  = ErrBits'(inner_ff);
      outer_ext  = ErrBits'(outer_ff);
      inc_small  = (inner_ext << 2) + ErrBits'(6);
      inc_big    = ((inner_ext - outer_ext) << 2) + ErrBits'(10);
      step_inner = main ? inner_ff + RADIUS_BITS'(1) : inner_ff;
      step_outer = (main && !err_neg) ? outer_ff - RADIUS_BITS'(1) : outer_ff;
      if (!main) begin
         step_err = err_ff;
      end else if (err_neg) begin
         step_err = err_ff + inc_small;
      end else begin
         step_err = err_ff + inc_big;
      end
      finish = !(step_inner < step_outer);
   end

   assign q_push             = accept && (opcode == OP_STEP) && busy_ff;
   assign d_flags.main       = main;
   assign d_flags.nonzero    = (inner_ff != '0);
   assign d_flags.outer_rows = main && !err_neg;
   assign d_flags.tail       = finish && (step_inner == step_outer);
   assign d_flags.finish     = finish;
   assign d_col              = centre_col_ff;
   assign d_row              = centre_row_ff;
   assign d_color            = color_ff;
   assign d_inner            = inner_ff;
   assign d_outer            = outer_ff;
   assign d_end              = step_inner;
   assign busy               = busy_ff;

   always_comb begin
      centre_col_in = centre_col_ff;
      centre_row_in = centre_row_ff;
      color_in      = color_ff;
      inner_in      = inner_ff;
      outer_in      = outer_ff;
      err_in        = err_ff;
      busy_in       = busy_ff;
      if (accept && (opcode == OP_START)) begin
         centre_col_in = req_tdata[10:0];
         centre_row_in = req_tdata[21:11];
         color_in      = req_tdata[55:32];
         inner_in      = '0;
         outer_in      = radius_r;
         err_in        = ErrBits'(3) - (ErrBits'(radius_r) << 1);
         busy_in       = 1'b1;
      end else if (q_push) begin
         inner_in = step_inner;
         outer_in = step_outer;
         err_in   = step_err;
         busy_in  = !finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_col_ff <= '0;
         centre_row_ff <= '0;
         color_ff      <= '0;
         inner_ff      <= '0;
         outer_ff      <= '0;
         err_ff        <= '0;
         busy_ff       <= 1'b0;
      end else begin
         centre_col_ff <= centre_col_in;
         centre_row_ff <= centre_row_in;
         color_ff      <= color_in;
         inner_ff      <= inner_in;
         outer_ff      <= outer_in;
         err_ff        <= err_in;
         busy_ff       <= busy_in;
      end
   end

endmodule

@@ sv/fcsg_back.sv @@
// Back end: turns each step descriptor into output register spans, one per unstalled cycle.
`timescale 1ns / 1ps

module fcsg_back import fcsg_pkg::*; #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  span_flags_type         d_flags,
   input  logic [10:0]            d_col,
   input  logic [10:0]            d_row,
   input  logic [23:0]            d_color,
   input  logic [RADIUS_BITS-1:0] d_inner,
   input  logic [RADIUS_BITS-1:0] d_outer,
   input  logic [RADIUS_BITS-1:0] d_end,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);

   logic                   cur_valid_ff, cur_valid_in;
   logic [SPAN_SLOTS-1:0]  mask_ff, mask_in;
   logic                   fin_ff, fin_in;
   logic [10:0]            col_ff, col_in;
   logic [10:0]            row_ff, row_in;
   logic [23:0]            color_ff, color_in;
   logic [RADIUS_BITS-1:0] a_ff, a_in;
   logic [RADIUS_BITS-1:0] b_ff, b_in;
   logic [RADIUS_BITS-1:0] t_ff, t_in;

   logic                   out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]  out_row_ff, out_row_in;
   logic [COORD_BITS-1:0]  out_xl_ff, out_xl_in;
   logic [COORD_BITS-1:0]  out_xr_ff, out_xr_in;
   logic [23:0]            out_color_ff, out_color_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_done_ff, out_done_in;

   span_slot_type          slot;
   logic [SPAN_SLOTS-1:0]  rest;
   logic                   last_pick;
   logic                   out_free;
   logic                   issue;
   logic [RADIUS_BITS-1:0] row_off, half;
   logic                   row_neg;
   logic [COORD_BITS-1:0]  row13, col13, off13, half13;
   logic [SPAN_SLOTS-1:0]  new_mask;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign issue     = cur_valid_ff && out_free;

   always_comb begin
      priority if (mask_ff[0]) begin
         slot = SLOT_UP_INNER;
      end else if (mask_ff[1]) begin
         slot = SLOT_DN_INNER;
      end else if (mask_ff[2]) begin
         slot = SLOT_UP_OUTER;
      end else if (mask_ff[3]) begin
         slot = SLOT_DN_OUTER;
      end else if (mask_ff[4]) begin
         slot = SLOT_UP_TAIL;
      end else begin
         slot = SLOT_DN_TAIL;
      end
   end

   assign rest      = mask_ff & ~(SPAN_SLOTS'(1) << slot);
   assign last_pick = (rest == '0);
   assign q_pop     = !q_empty && (!cur_valid_ff || (issue && last_pick));

   always_comb begin
      unique case (slot)
         SLOT_UP_INNER: begin
            row_off = a_ff;
            row_neg = 1'b1;
            half    = b_ff;
         end
         SLOT_DN_INNER: begin
            row_off = a_ff;
            row_neg = 1'b0;
            half    = b_ff;
         end
         SLOT_UP_OUTER: begin
            row_off = b_ff;
            row_neg = 1'b1;
            half    = a_ff;
         end
         SLOT_DN_OUTER: begin
            row_off = b_ff;
            row_neg = 1'b0;
            half    = a_ff;
         end
         SLOT_UP_TAIL: begin
            row_off = t_ff;
            row_neg = 1'b1;
            half    = t_ff;
         end
         SLOT_DN_TAIL: begin
            row_off = t_ff;
            row_neg = 1'b0;
            half    = t_ff;
         end
         default: begin
            row_off = t_ff;
            row_neg = 1'b0;
            half    = t_ff;
         end
      endcase
   end

   always_comb begin
      row13  = COORD_BITS'(row_ff);
      col13  = COORD_BITS'(col_ff);
      off13  = COORD_BITS'(row_off);
      half13 = COORD_BITS'(half);
   end

   assign new_mask = {d_flags.tail, d_flags.tail, d_flags.outer_rows, d_flags.outer_rows,
                      d_flags.main && d_flags.nonzero, d_flags.main};

   always_comb begin
      cur_valid_in = cur_valid_ff;
      mask_in      = mask_ff;
      fin_in       = fin_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      color_in     = color_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      t_in         = t_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         mask_in      = new_mask;
         fin_in       = d_flags.finish;
         col_in       = d_col;
         row_in       = d_row;
         color_in     = d_color;
         a_in         = d_inner;
         b_in         = d_outer;
         t_in         = d_end;
      end else if (issue) begin
         mask_in      = rest;
         cur_valid_in = !last_pick;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_row_in   = out_row_ff;
      out_xl_in    = out_xl_ff;
      out_xr_in    = out_xr_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (issue) begin
         out_valid_in = 1'b1;
         out_row_in   = row_neg ? row13 - off13 : row13 + off13;
         out_xl_in    = col13 - half13;
         out_xr_in    = col13 + half13;
         out_color_in = color_ff;
         out_last_in  = last_pick;
         out_done_in  = last_pick && fin_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff       <= fin_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      color_ff     <= color_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      t_ff         <= t_in;
      out_row_ff   <= out_row_in;
      out_xl_ff    <= out_xl_in;
      out_xr_ff    <= out_xr_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_color_ff, out_xr_ff, out_xl_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

endmodule
